// ===== hw/rtl/bb3_pkg.sv =====
// Package with shared types and constants of the 3x3 box blur.
package bb3_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_DIV,
      ST_OUT
   } state_type;

   localparam int unsigned CFG_IDX_W = 1;
   localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   localparam logic [10:0] WIDTH_RESET  = 11'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   // Sum of up to nine 8-bit values needs 12 bits; doubled plus count, 13 bits.
   localparam int unsigned SUM_W = 13;
   localparam int unsigned QUO_W = 8;

   typedef struct packed {
      logic start;
      logic [SUM_W-1:0] num;
      logic [4:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [QUO_W-1:0] quo;
   } div_rsp_type;

endpackage

// ===== hw/rtl/bb3_stream_if.sv =====
// Valid/ready channel interface carrying a generic payload.
interface bb3_stream_if #(
   parameter int unsigned DATA_W = 24
);
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bb3_divider.sv =====
// Restoring divider producing one quotient bit per cycle.
module bb3_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  bb3_pkg::div_req_type req,
   output bb3_pkg::div_rsp_type rsp
);
   logic [bb3_pkg::SUM_W-1:0] rem_ff, rem_in;
   logic [bb3_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [5:0]                den_ff, den_in;
   logic [3:0]                cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [bb3_pkg::SUM_W+5:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (req.start) begin
         rem_in  = req.num;
         den_in  = {req.den, 1'b0};
         quo_in  = '0;
         cnt_in  = 4'(bb3_pkg::QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Quotient fits in 8 bits, so only eight shifted compares are needed.
         trial = {6'd0, rem_ff} - ({13'd0, den_ff} << cnt_ff);
         if (!trial[bb3_pkg::SUM_W+5]) begin
            rem_in = trial[bb3_pkg::SUM_W-1:0];
            quo_in = quo_ff | (8'd1 << cnt_ff[2:0]);
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
endmodule

// ===== hw/rtl/box_blur_3x3.sv =====
// Top level of the 3x3 box blur over a raster-order RGB pixel stream.
// Usage: pixels enter on the req channel (red, green, blue) in raster order;
// blurred pixels leave on the rsp channel with their row and column,
// last_of_run on the final result of each input item and image_done on the
// final result of the image. The user must set the image size through the
// csr port only while the block is idle; the block itself does not enforce
// this. A write restarts the image at row 0, column 0.
// Each input item causes zero to four results. An item first reads the line
// stores, then for each result sums the window, divides each color channel in
// turn in the shared bit-serial divider and loads the output register; most
// of the time per result is spent in the divider. req_ready stays low from the
// accept until the last result of the item is loaded, or until the line stores
// are read for an item without results, so no new item is taken before then.
// Reset returns the block to idle at row 0, column 0 with the register reset
// sizes; line stores are not cleared since edge masking hides unwritten
// entries. When the receiver stalls, the result holds in the output register
// and the block waits before loading the next result.
module box_blur_3x3 #(
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [bb3_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [12:0]                     csr_write_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_in_red,
   input  logic [7:0]                      req_in_green,
   input  logic [7:0]                      req_in_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_red,
   output logic [7:0]                      rsp_out_green,
   output logic [7:0]                      rsp_out_blue,
   output logic [11:0]                     rsp_out_row,
   output logic [9:0]                      rsp_out_column,
   output logic                            rsp_last_of_run,
   output logic                            rsp_image_done
);
   localparam int unsigned AW = $clog2(MAX_WIDTH);
   localparam int unsigned HW = $clog2(MAX_HEIGHT);
   localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

   function automatic logic [1:0] slot_sel_of(input logic [3:0] p);
      logic [1:0] s;
      s = 2'd3;
      if (p[2]) s = 2'd2;
      if (p[1]) s = 2'd1;
      if (p[0]) s = 2'd0;
      return s;
   endfunction

   bb3_pkg::state_type state_ff, state_in;

   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [AW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;

   logic [23:0] older_mem [MAX_WIDTH];
   logic [23:0] prev_mem [MAX_WIDTH];
   logic [23:0] older_rd_ff, prev_rd_ff;
   logic [23:0] pix_ff;
   logic [23:0] win_ff [6];

   // Effective dimensions, clamped to 1..MAX.
   logic [CW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   always_comb begin
      if (width_ff == 11'd0) w_eff = CW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(width_ff);
      if (height_ff == 13'd0) h_eff = RW'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
      else h_eff = RW'(height_ff);
   end

   logic last_col, last_row;
   assign last_col = (CW'(col_ff) == w_eff - CW'(1));
   assign last_row = (RW'(row_ff) == h_eff - RW'(1));

   // Result slots: bit0 col c-1 row r-1, bit1 col c-1 row r,
   // bit2 col c row r-1, bit3 col c row r.
   logic [3:0] slots;
   always_comb begin
      slots[0] = (col_ff != '0) && (row_ff != '0);
      slots[1] = (col_ff != '0) && last_row;
      slots[2] = last_col && (row_ff != '0);
      slots[3] = last_col && last_row;
   end

   logic [3:0] pend_ff, pend_in;
   logic [1:0] slot_ff, slot_in;
   logic [1:0] chan_ff, chan_in;
   logic [7:0] quo_ff [3];
   logic [11:0] sum_r_ff, sum_g_ff, sum_b_ff;
   logic [11:0] sum_r_in, sum_g_in, sum_b_in;
   logic [3:0] cnt_ff, cnt_in;
   logic out_valid_ff;

   bb3_pkg::div_req_type div_req;
   bb3_pkg::div_rsp_type div_rsp;

   bb3_divider u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   logic [23:0] colv [3][3];
   logic [2:0] colok, rowok;
   always_comb begin
      sum_r_in = '0;
      sum_g_in = '0;
      sum_b_in = '0;
      cnt_in   = '0;
      // Columns c-1 case: left=win[0..2] (c>=2), centre=win[3..5], right=fresh.
      // Column c case: left=win[3..5] (c>=1), centre=fresh, right=none.
      colv[1][0] = older_rd_ff;
      colv[1][1] = prev_rd_ff;
      colv[1][2] = pix_ff;
      if (!slot_ff[1]) begin
         for (int k = 0; k < 3; k++) begin
            colv[0][k] = win_ff[k];
            colv[1][k] = win_ff[k+3];
         end
         colv[2][0] = older_rd_ff;
         colv[2][1] = prev_rd_ff;
         colv[2][2] = pix_ff;
         colok = {1'b1, 1'b1, (col_ff > AW'(1))};
      end else begin
         for (int k = 0; k < 3; k++) begin
            colv[0][k] = win_ff[k+3];
            colv[2][k] = '0;
         end
         colok = {1'b0, 1'b1, (col_ff != '0)};
      end
      if (!slot_ff[0]) rowok = {1'b1, 1'b1, (row_ff > HW'(1))};
      else rowok = {1'b1, (row_ff != '0), 1'b0};
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            if (colok[i] && rowok[k]) begin
               sum_r_in = sum_r_in + 12'(colv[i][k][23:16]);
               sum_g_in = sum_g_in + 12'(colv[i][k][15:8]);
               sum_b_in = sum_b_in + 12'(colv[i][k][7:0]);
               cnt_in   = cnt_in + 4'd1;
            end
         end
      end
   end

   logic [11:0] chan_sum;
   always_comb begin
      case (chan_ff)
         2'd0:    chan_sum = sum_r_ff;
         2'd1:    chan_sum = sum_g_ff;
         default: chan_sum = sum_b_ff;
      endcase
   end

   logic req_fire;
   assign req_fire = req_valid && req_ready;
   // A waiting result sits in the output register, so the next item may start.
   assign req_ready = (state_ff == bb3_pkg::ST_IDLE);

   logic out_load;
   logic [AW-1:0] out_col;
   logic [HW-1:0] out_row;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      slot_in  = slot_ff;
      chan_in  = chan_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      out_load = 1'b0;
      div_req  = '0;
      case (state_ff)
         bb3_pkg::ST_IDLE: begin
            if (req_fire) state_in = bb3_pkg::ST_READ;
         end
         bb3_pkg::ST_READ: begin
            pend_in = slots;
            if (slots == 4'd0) begin
               state_in = bb3_pkg::ST_IDLE;
            end else begin
               slot_in  = slot_sel_of(slots);
               state_in = bb3_pkg::ST_CALC;
            end
         end
         bb3_pkg::ST_CALC: begin
            chan_in  = 2'd0;
            state_in = bb3_pkg::ST_DIV;
            div_req.start = 1'b1;
            div_req.num   = {sum_r_in, 1'b0} + bb3_pkg::SUM_W'(cnt_in);
            div_req.den   = {1'b0, cnt_in};
         end
         bb3_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               if (chan_ff == 2'd2) begin
                  state_in = bb3_pkg::ST_OUT;
               end else begin
                  chan_in = chan_ff + 2'd1;
                  div_req.start = 1'b1;
                  div_req.num = {(chan_ff == 2'd0) ? sum_g_ff : sum_b_ff, 1'b0}
                                + bb3_pkg::SUM_W'(cnt_ff);
                  div_req.den = {1'b0, cnt_ff};
               end
            end
         end
         bb3_pkg::ST_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               pend_in = pend_ff & ~(4'd1 << slot_ff);
               if (pend_in == 4'd0) begin
                  state_in = bb3_pkg::ST_IDLE;
               end else begin
                  slot_in  = slot_sel_of(pend_in);
                  state_in = bb3_pkg::ST_CALC;
               end
            end
         end
         default: state_in = bb3_pkg::ST_IDLE;
      endcase
      // Position advances once the item leaves the block.
      if ((state_ff == bb3_pkg::ST_READ && slots == 4'd0) ||
          (state_in == bb3_pkg::ST_IDLE && state_ff == bb3_pkg::ST_OUT)) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + HW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
      if (csr_write_enable && (csr_index == bb3_pkg::REG_IMAGE_WIDTH ||
                               csr_index == bb3_pkg::REG_IMAGE_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
      end
   end

   assign out_col = slot_ff[1] ? col_ff : col_ff - AW'(1);
   assign out_row = slot_ff[0] ? row_ff : row_ff - HW'(1);

   // Line stores: read address on accept, write back after the read.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         older_rd_ff <= older_mem[col_ff];
         prev_rd_ff  <= prev_mem[col_ff];
         pix_ff      <= {req_in_red, req_in_green, req_in_blue};
      end
      if (state_ff == bb3_pkg::ST_READ) begin
         older_mem[col_ff] <= prev_rd_ff;
         prev_mem[col_ff]  <= pix_ff;
      end
   end

   // Window shifts once the item is finished.
   always_ff @(posedge clock) begin
      if (state_ff != bb3_pkg::ST_IDLE && state_in == bb3_pkg::ST_IDLE) begin
         for (int k = 0; k < 3; k++) win_ff[k] <= win_ff[k+3];
         win_ff[3] <= older_rd_ff;
         win_ff[4] <= prev_rd_ff;
         win_ff[5] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == bb3_pkg::ST_CALC) begin
         sum_r_ff <= sum_r_in;
         sum_g_ff <= sum_g_in;
         sum_b_ff <= sum_b_in;
         cnt_ff   <= cnt_in;
      end
      if (div_rsp.done) quo_ff[chan_ff] <= div_rsp.quo;
      if (out_load) begin
         rsp_out_red     <= quo_ff[0];
         rsp_out_green   <= quo_ff[1];
         rsp_out_blue    <= quo_ff[2];
         rsp_out_row     <= 12'(out_row);
         rsp_out_column  <= 10'(out_col);
         rsp_last_of_run <= (pend_in == 4'd0);
         rsp_image_done  <= (pend_in == 4'd0) && last_col && last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bb3_pkg::ST_IDLE;
         width_ff     <= bb3_pkg::WIDTH_RESET;
         height_ff    <= bb3_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= '0;
         slot_ff      <= '0;
         chan_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
         slot_ff  <= slot_in;
         chan_ff  <= chan_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         if (csr_write_enable && csr_index == bb3_pkg::REG_IMAGE_WIDTH)
            width_ff <= csr_write_data[10:0];
         if (csr_write_enable && csr_index == bb3_pkg::REG_IMAGE_HEIGHT)
            height_ff <= csr_write_data;
      end
   end

   assign rsp_valid = out_valid_ff;

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == bb3_pkg::ST_IDLE))
      else $error("req_ready high while an item is in work");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bb3_pkg::ST_IDLE) |-> (CW'(col_ff) < w_eff || w_eff == '0))
      else $error("column position beyond image width");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == bb3_pkg::ST_DIV))
      else $error("divider finished outside the divide phase");
`endif
endmodule

// ===== sim/box_blur_3x3_test.sv =====
// Self-checking testbench of the 3x3 box blur with a scoreboard class.
module box_blur_3x3_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LINE_MAX  = 1024;
   localparam int unsigned ROWS_MAX  = 4096;
   localparam int unsigned CYCLE_CAP = 600000;
   localparam int unsigned SETTLE    = 60;

   typedef logic [23:0] pixel_type;
   typedef pixel_type column_type [3];

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] row;
      logic [9:0]  column;
      logic        last_of_run;
      logic        image_done;
   } blurred_type;

   class blur_scoreboard;
      pixel_type   older_row [LINE_MAX];
      pixel_type   upper_row [LINE_MAX];
      column_type  left_col;
      column_type  mid_col;
      int unsigned row_pos, col_pos;
      logic [10:0] width_reg;
      logic [12:0] height_reg;
      blurred_type pending [$];
      int unsigned errors;

      function new();
         row_pos = 0;
         col_pos = 0;
         width_reg = bb3_pkg::WIDTH_RESET;
         height_reg = bb3_pkg::HEIGHT_RESET;
         errors = 0;
      endfunction

      function void set_register(logic [bb3_pkg::CFG_IDX_W-1:0] idx, logic [12:0] value);
         if (idx == bb3_pkg::REG_IMAGE_WIDTH) width_reg = value[10:0];
         else height_reg = value;
         row_pos = 0;
         col_pos = 0;
      endfunction

      // Rounded mean over the rows and columns selected by the two masks.
      function void add_blurred(column_type a, column_type b, column_type d,
                                logic [2:0] colmask, logic [2:0] rowmask,
                                int unsigned row, int unsigned col);
         int unsigned total [3];
         int unsigned n;
         column_type cols [3];
         blurred_type res;
         total = '{0, 0, 0};
         n = 0;
         cols[0] = a;
         cols[1] = b;
         cols[2] = d;
         for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++)
               if (colmask[j] && rowmask[i]) begin
                  total[0] += cols[j][i][23:16];
                  total[1] += cols[j][i][15:8];
                  total[2] += cols[j][i][7:0];
                  n++;
               end
         res = '0;
         res.red = 8'((2 * total[0] + n) / (2 * n));
         res.green = 8'((2 * total[1] + n) / (2 * n));
         res.blue = 8'((2 * total[2] + n) / (2 * n));
         res.row = 12'(row);
         res.column = 10'(col);
         pending.push_back(res);
      endfunction

      function void add_column(column_type a, column_type b, column_type d,
                               logic [2:0] colmask, int unsigned r, int unsigned h,
                               int unsigned col);
         if (r >= 1) add_blurred(a, b, d, colmask, {2'b11, r >= 2}, r - 1, col);
         if (r == h - 1) add_blurred(a, b, d, colmask, {1'b1, r >= 1, 1'b0}, r, col);
      endfunction

      function void note_pixel(pixel_type px);
         int unsigned w, h, c, r, before_count;
         column_type fresh;
         blurred_type tail;
         w = (width_reg == 0) ? 1 : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
         h = (height_reg == 0) ? 1 : (height_reg > ROWS_MAX) ? ROWS_MAX : height_reg;
         c = (col_pos >= w) ? 0 : col_pos;
         r = (row_pos >= h) ? 0 : row_pos;
         fresh[0] = older_row[c];
         fresh[1] = upper_row[c];
         fresh[2] = px;
         older_row[c] = fresh[1];
         upper_row[c] = px;
         before_count = pending.size();
         if (c >= 1) add_column(left_col, mid_col, fresh, {2'b11, c >= 2}, r, h, c - 1);
         if (c == w - 1) add_column(mid_col, fresh, fresh, {1'b0, 1'b1, c >= 1}, r, h, c);
         if (pending.size() > before_count) begin
            tail = pending.pop_back();
            tail.last_of_run = 1'b1;
            tail.image_done = (r == h - 1) && (c == w - 1);
            pending.push_back(tail);
         end
         left_col = mid_col;
         mid_col = fresh;
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
            row_pos = r;
         end
      endfunction

      function void check_result(blurred_type got);
         blurred_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.red != want.red || got.green != want.green || got.blue != want.blue ||
             got.row != want.row || got.column != want.column ||
             got.last_of_run != want.last_of_run || got.image_done != want.image_done) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [bb3_pkg::CFG_IDX_W-1:0] csr_index;
   logic [12:0] csr_write_data;
   bb3_stream_if #(.DATA_W(24)) req_ch ();
   bb3_stream_if #(.DATA_W(48)) rsp_ch ();

   blur_scoreboard sb;
   int unsigned cycles = 0;
   int unsigned burst_left;
   int unsigned items_sent;
   bit pressure_done;
   int unsigned stall_mode = 0;

   box_blur_3x3 dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_in_red(req_ch.data[23:16]),
      .req_in_green(req_ch.data[15:8]),
      .req_in_blue(req_ch.data[7:0]),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_out_red(rsp_ch.data[47:40]),
      .rsp_out_green(rsp_ch.data[39:32]),
      .rsp_out_blue(rsp_ch.data[31:24]),
      .rsp_out_row(rsp_ch.data[23:12]),
      .rsp_out_column(rsp_ch.data[11:2]),
      .rsp_last_of_run(rsp_ch.data[1]),
      .rsp_image_done(rsp_ch.data[0])
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_result(blurred_type'(rsp_ch.data));

   // The receiver mode is picked at random among always ready, random stalls
   // and a fixed pattern.
   always @(posedge clock) begin
      if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
         default: rsp_ch.ready <= (cycles % 5 < 2);
      endcase
   end

   task automatic wait_idle();
      while (sb.pending.size() != 0) @(posedge clock);
      // An item without results may still be in work.
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_size(int unsigned w, int unsigned h);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= bb3_pkg::REG_IMAGE_WIDTH;
      csr_write_data <= 13'(w);
      @(posedge clock);
      sb.set_register(bb3_pkg::REG_IMAGE_WIDTH, 13'(w));
      csr_index <= bb3_pkg::REG_IMAGE_HEIGHT;
      csr_write_data <= 13'(h);
      @(posedge clock);
      sb.set_register(bb3_pkg::REG_IMAGE_HEIGHT, 13'(h));
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_pixel(pixel_type px);
      int unsigned gap;
      req_ch.valid <= 1'b1;
      req_ch.data <= px;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_pixel(px);
      items_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else burst_left--;
   endtask

   task automatic finish_burst();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic pixel_type random_pixel();
      case ($urandom_range(0, 7))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 8'($urandom), 8'($urandom)};
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic run_phase(int unsigned w, int unsigned h, int unsigned count);
      finish_burst();
      write_size(w, h);
      for (int unsigned k = 0; k < count; k++) begin
         if (!pressure_done && items_sent >= 200) begin
            pressure_done = 1;
            finish_burst();
            while (sb.pending.size() != 0) @(posedge clock);
         end
         send_pixel(random_pixel());
      end
   endtask

   initial begin
      int unsigned w, h;
      pixel_type corner_set [9];
      sb = new();
      burst_left = 0;
      items_sent = 0;
      pressure_done = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = bb3_pkg::REG_IMAGE_WIDTH;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a 3x3 image of extremes, then zero sizes read as one.
      corner_set = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFF00FF,
                     24'h00FF00, 24'hFFFFFF, 24'h010101, 24'hFEFEFE};
      finish_burst();
      write_size(3, 3);
      foreach (corner_set[i]) send_pixel(corner_set[i]);
      finish_burst();
      write_size(0, 0);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'h80C0A5);
      run_phase(1, 3, 3);
      run_phase(3, 1, 3);
      // Oversized registers saturate; only a few pixels before the restart.
      run_phase(2047, 2, 6);

      while (items_sent < 470) begin
         case ($urandom_range(0, 9))
            0: run_phase(2047, 8191, $urandom_range(2, 8));
            1: run_phase(1024, 2, $urandom_range(4, 10));
            2: run_phase(1, 8191, $urandom_range(3, 10));
            default: begin
               w = $urandom_range(1, 7);
               h = $urandom_range(1, 5);
               run_phase(w, h, w * h * $urandom_range(1, 2) + $urandom_range(0, 2));
            end
         endcase
      end
      finish_burst();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
